/* hdl/generational_handle_table_assert.svh */
// assertion macros for the handle table checker
`ifndef GENERATIONAL_HANDLE_TABLE_ASSERT_SVH
`define GENERATIONAL_HANDLE_TABLE_ASSERT_SVH

// condition and consequence in the same cycle
`define GHT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("handle table check failed");

// consequence in the cycle after the condition
`define GHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("handle table check failed");

`endif

/* hdl/ght_pkg.sv */
// shared types and constants for the generational handle table
`default_nettype none

package ght_pkg;

    // default sizes
    localparam int SLOTS_DEF       = 1024;
    localparam int ENTITY_BITS_DEF = 32;

    // field widths on the stream ports
    localparam int FUNC_W   = 2;
    localparam int IDX_W    = 10;
    localparam int VER_W    = 8;
    localparam int ENT_W    = 32;
    localparam int STATUS_W = 2;

    // stream bus widths, tdata fields packed from the lowest bit, padded to bytes
    localparam int TDATA_RAW = IDX_W + VER_W + ENT_W;
    localparam int TDATA_W   = ((TDATA_RAW + 7) / 8) * 8;
    localparam int TUSER_W   = 2;

    // operation codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_GET    = 2'd2,
        FUNC_SET    = 2'd3
    } t_func;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_MISMATCH = 2'd1,
        STAT_FULL     = 2'd2,
        STAT_RANGE    = 2'd3
    } t_status;

    // control sequencer states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

endpackage

`default_nettype wire

/* hdl/ght_ram.sv */
// generic single-write, single-read synchronous ram with registered read
`default_nettype none

module ght_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* hdl/generational_handle_table.sv */
// generational handle table top level: slot store, free-index stack and sequencer
`default_nettype none

// Handle table of SLOTS slots, each holding an entity and an 8-bit version.
// One request per stream item: add, remove, get or set (tuser), each
// answered by exactly one result item carrying a status in tuser. In the
// accept cycle the slot memory and the free-stack memory are read
// (synchronous, registered read); in S_EXEC the slot or stack entry is
// written back and the result is loaded into the output register. The next
// request is taken no earlier than the cycle after that writeback, so reads
// always see committed data. A result waiting at the output does not block
// the next request; the writeback of that next one waits until the output
// register is free. Slots and stack entries are not cleared at reset; the
// used-slot and free counts keep unwritten entries out of reach. Entities
// are stored in min(ENTITY_BITS, 32) bits.
module generational_handle_table #(
    parameter int SLOTS       = ght_pkg::SLOTS_DEF,
    parameter int ENTITY_BITS = ght_pkg::ENTITY_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // request side
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    // slot_index, handle_version, entity_value
    input  wire logic [ght_pkg::TDATA_W-1:0]  s_axis_tdata,
    // func
    input  wire logic [ght_pkg::TUSER_W-1:0]  s_axis_tuser,
    // result side
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // out_index, out_version, out_entity
    output logic      [ght_pkg::TDATA_W-1:0]  m_axis_tdata,
    // status
    output logic      [ght_pkg::TUSER_W-1:0]  m_axis_tuser
);

    import ght_pkg::*;

    localparam int IW  = $clog2(SLOTS);
    localparam int CW  = $clog2(SLOTS + 1);
    localparam int XW  = IW + IDX_W;
    localparam int EW  = (ENTITY_BITS < ENT_W) ? ENTITY_BITS : ENT_W;
    localparam int SW  = EW + VER_W;

    // control state
    t_state              r_state, n_state;
    logic [CW-1:0]       r_free_count, n_free_count;
    logic [CW-1:0]       r_used, n_used;
    logic [VER_W-1:0]    r_vctr, n_vctr;
    logic                r_out_valid, n_out_valid;

    // captured request
    t_func               r_func;
    logic [IDX_W-1:0]    r_idx;
    logic [VER_W-1:0]    r_hver;
    logic [EW-1:0]       r_ent;

    // output register payload
    t_status             r_out_status;
    logic [TDATA_W-1:0]  r_out_data;

    // request unpacking
    logic                w_accept;
    logic                w_fire;
    logic [IDX_W-1:0]    w_in_idx;
    logic [XW-1:0]       w_in_idx_ext;
    logic [XW-1:0]       w_idx_ext;
    logic [IW-1:0]       w_idx_slot;
    logic [CW-1:0]       w_fc_dec;
    logic                w_in_range;

    // memory ports
    logic [SW-1:0]       w_slot_rd;
    logic [EW-1:0]       w_slot_rd_ent;
    logic [VER_W-1:0]    w_slot_rd_ver;
    logic [IW-1:0]       w_stk_rd;
    logic                w_slot_we;
    logic [IW-1:0]       w_slot_waddr;
    logic [SW-1:0]       w_slot_wdata;
    logic                w_stk_we;

    // result build
    logic [IW-1:0]       w_add_slot;
    logic                w_add_ok;
    logic [XW-1:0]       w_slot_ext;
    t_status             w_status;
    logic [IDX_W-1:0]    w_oidx;
    logic [VER_W-1:0]    w_over;
    logic [ENT_W-1:0]    w_oent;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_fire        = (r_state == S_EXEC) && (!r_out_valid || m_axis_tready);

    assign w_in_idx      = s_axis_tdata[IDX_W-1:0];
    assign w_in_idx_ext  = XW'(w_in_idx);
    assign w_idx_ext     = XW'(r_idx);
    assign w_idx_slot    = w_idx_ext[IW-1:0];
    assign w_fc_dec      = r_free_count - CW'(1);
    assign w_in_range    = 32'(r_idx) < 32'(r_used);

    assign w_slot_rd_ent = w_slot_rd[EW-1:0];
    assign w_slot_rd_ver = w_slot_rd[SW-1:EW];

    // slot store: version above entity
    ght_ram #(
        .WIDTH (SW),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_fire && w_slot_we),
        .i_wr_addr (w_slot_waddr),
        .i_wr_data (w_slot_wdata),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_in_idx_ext[IW-1:0]),
        .o_rd_data (w_slot_rd)
    );

    // free-index stack, top read on every accepted request
    ght_ram #(
        .WIDTH (IW),
        .DEPTH (SLOTS)
    ) u_stack_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_fire && w_stk_we),
        .i_wr_addr (r_free_count[IW-1:0]),
        .i_wr_data (w_idx_slot),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_fc_dec[IW-1:0]),
        .o_rd_data (w_stk_rd)
    );

    // operation decode and writeback
    always_comb begin
        w_slot_we    = 1'b0;
        w_slot_waddr = w_idx_slot;
        w_slot_wdata = {r_vctr, w_slot_rd_ent};
        w_stk_we     = 1'b0;
        w_add_slot   = '0;
        w_add_ok     = 1'b0;
        n_free_count = r_free_count;
        n_used       = r_used;
        n_vctr       = r_vctr;
        w_status     = STAT_OK;
        w_oidx       = r_idx;
        w_over       = '0;
        w_oent       = '0;

        case (r_func)
            FUNC_ADD: begin
                if (r_free_count != '0) begin
                    w_add_slot   = w_stk_rd;
                    n_free_count = w_fc_dec;
                    w_add_ok     = 1'b1;
                end else if (r_used < CW'(SLOTS)) begin
                    w_add_slot = r_used[IW-1:0];
                    n_used     = r_used + CW'(1);
                    w_add_ok   = 1'b1;
                end else begin
                    w_status = STAT_FULL;
                end
                if (w_add_ok) begin
                    w_slot_we    = 1'b1;
                    w_slot_waddr = w_add_slot;
                    w_slot_wdata = {r_vctr, r_ent};
                    n_vctr       = r_vctr + VER_W'(1);
                    w_over       = r_vctr;
                end
            end
            FUNC_REMOVE: begin
                if (!w_in_range) begin
                    w_status = STAT_RANGE;
                end else begin
                    w_slot_we = 1'b1;
                    n_vctr    = r_vctr + VER_W'(1);
                    if (r_free_count < CW'(SLOTS)) begin
                        w_stk_we     = 1'b1;
                        n_free_count = r_free_count + CW'(1);
                    end
                end
            end
            FUNC_GET: begin
                if (!w_in_range) begin
                    w_status = STAT_RANGE;
                end else if (w_slot_rd_ver == r_hver) begin
                    w_oent = ENT_W'(w_slot_rd_ent);
                end else begin
                    w_status = STAT_MISMATCH;
                end
            end
            FUNC_SET: begin
                if (!w_in_range) begin
                    w_status = STAT_RANGE;
                end else begin
                    w_slot_we    = 1'b1;
                    w_slot_wdata = {w_slot_rd_ver, r_ent};
                end
            end
            default: begin
                w_status = STAT_OK;
            end
        endcase

        w_slot_ext = XW'(w_add_slot);
        if (w_add_ok) begin
            w_oidx = w_slot_ext[IDX_W-1:0];
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_fire) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register valid
    always_comb begin
        n_out_valid = r_out_valid && !m_axis_tready;
        if (w_fire) begin
            n_out_valid = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_free_count <= '0;
            r_used       <= '0;
            r_vctr       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (w_fire) begin
                r_free_count <= n_free_count;
                r_used       <= n_used;
                r_vctr       <= n_vctr;
            end
        end
    end

    // request capture and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func <= t_func'(s_axis_tuser[FUNC_W-1:0]);
            r_idx  <= w_in_idx;
            r_hver <= s_axis_tdata[IDX_W+VER_W-1:IDX_W];
            r_ent  <= s_axis_tdata[IDX_W+VER_W+EW-1:IDX_W+VER_W];
        end
        if (w_fire) begin
            r_out_status <= w_status;
            r_out_data   <= TDATA_W'({w_oent, w_over, w_oidx});
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = TUSER_W'(r_out_status);

endmodule

`default_nettype wire

/* hdl/ght_checker.sv */
// port-level checker for the generational handle table, bound to the top level
`default_nettype none

`include "generational_handle_table_assert.svh"

module ght_checker (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_s_tvalid,
    input  wire logic                         i_s_tready,
    input  wire logic                         i_m_tvalid,
    input  wire logic                         i_m_tready,
    // out_index, out_version, out_entity
    input  wire logic [ght_pkg::TDATA_W-1:0]  i_m_tdata,
    // status
    input  wire logic [ght_pkg::TUSER_W-1:0]  i_m_tuser
);

    import ght_pkg::*;

    logic w_in_acc;

    assign w_in_acc = i_s_tvalid && i_s_tready;

    // one request in flight: no accept right after an accept
    `GHT_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, w_in_acc, !i_s_tready)

    // a stalled result holds
    `GHT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser))

    // failed requests carry no version and no entity
    `GHT_ASSERT_SAME(a_fail_zero, i_clk, i_rst_n, i_m_tvalid && (i_m_tuser != TUSER_W'(STAT_OK)), i_m_tdata[TDATA_W-1:IDX_W] == '0)

    // a fresh result follows the accept of its request through S_EXEC and the output register
    `GHT_ASSERT_SAME(a_result_latency, i_clk, i_rst_n, $rose(i_m_tvalid), $past(w_in_acc, 2))

endmodule

bind generational_handle_table ght_checker u_ght_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser)
);

`default_nettype wire

/* dv/ght_tb_pkg.sv */
`timescale 1ns / 1ps
// scoreboard class that mirrors the handle table state and checks each result
package ght_tb_pkg;

    import ght_pkg::*;

    localparam int TABLE_SLOTS = SLOTS_DEF;

    // one result item as the block should answer it
    typedef struct packed {
        t_status          status;
        logic [IDX_W-1:0] index;
        logic [VER_W-1:0] version;
        logic [ENT_W-1:0] entity;
    } slot_result_t;

    class handle_table_scoreboard;
        // mirror of the slot store and the free-index stack
        bit [ENT_W-1:0] entity_mem   [TABLE_SLOTS];
        bit [VER_W-1:0] version_mem  [TABLE_SLOTS];
        bit [IDX_W-1:0] free_indexes [TABLE_SLOTS];
        int unsigned    free_count;
        int unsigned    used_count;
        bit [VER_W-1:0] version_ctr;
        slot_result_t   expected_results [$];
        int unsigned    errors;

        function new();
            free_count  = 0;
            used_count  = 0;
            version_ctr = '0;
            errors      = 0;
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction

        // advance the mirror by one accepted request and queue its answer
        function void apply_request(t_func op, bit [IDX_W-1:0] idx, bit [VER_W-1:0] hver,
                                    bit [ENT_W-1:0] ent);
            slot_result_t res;
            int unsigned  slot;
            bit           granted;
            res.status  = STAT_OK;
            res.index   = idx;
            res.version = '0;
            res.entity  = '0;
            slot        = 0;
            granted     = 1'b0;
            if (op == FUNC_ADD) begin
                // reuse a freed slot first, then a fresh one
                if (free_count > 0) begin
                    free_count--;
                    slot    = free_indexes[free_count];
                    granted = 1'b1;
                end else if (used_count < TABLE_SLOTS) begin
                    slot = used_count;
                    used_count++;
                    granted = 1'b1;
                end else begin
                    res.status = STAT_FULL;
                end
                if (granted) begin
                    entity_mem[slot]  = ent;
                    version_mem[slot] = version_ctr;
                    version_ctr++;
                    res.index   = IDX_W'(slot);
                    res.version = version_mem[slot];
                end
            end else if (idx >= used_count) begin
                res.status = STAT_RANGE;
            end else begin
                case (op)
                    FUNC_REMOVE: begin
                        // restamp, push unless the stack is already full
                        version_mem[idx] = version_ctr;
                        version_ctr++;
                        if (free_count < TABLE_SLOTS) begin
                            free_indexes[free_count] = idx;
                            free_count++;
                        end
                    end
                    FUNC_GET: begin
                        if (version_mem[idx] == hver) res.entity = entity_mem[idx];
                        else res.status = STAT_MISMATCH;
                    end
                    default: begin
                        entity_mem[idx] = ent;
                    end
                endcase
            end
            expected_results.push_back(res);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40) $display("ERROR %0t: %s", $time, msg);
        endtask

        // compare one observed result with the oldest expected one
        task compare_result(slot_result_t got);
            slot_result_t want;
            if (expected_results.size() == 0) begin
                report($sformatf("result with no request waiting: status %0d index %0d",
                                 got.status, got.index));
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, expected %0d", got.status, want.status));
            if (got.index !== want.index)
                report($sformatf("index %0d, expected %0d", got.index, want.index));
            if (got.version !== want.version)
                report($sformatf("version %0d, expected %0d", got.version, want.version));
            if (got.entity !== want.entity)
                report($sformatf("entity %h, expected %h", got.entity, want.entity));
        endtask
    endclass

endpackage

/* dv/generational_handle_table_tb.sv */
`timescale 1ns / 1ps
// testbench top for the generational handle table
module generational_handle_table_tb;

    import ght_pkg::*;
    import ght_tb_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;

    typedef enum int {
        READY_ALWAYS,
        READY_RANDOM,
        READY_PATTERN
    } t_ready_mode;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    // slot_index, handle_version, entity_value
    logic [TDATA_W-1:0] s_axis_tdata;
    // func
    logic [TUSER_W-1:0] s_axis_tuser;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    // out_index, out_version, out_entity
    logic [TDATA_W-1:0] m_axis_tdata;
    // status
    logic [TUSER_W-1:0] m_axis_tuser;

    handle_table_scoreboard sb;
    slot_result_t           observed;
    bit                     sender_gaps = 1'b0;
    int                     burst_left = 0;
    t_ready_mode            ready_mode = READY_ALWAYS;
    int unsigned            hold_requests = 0;
    int unsigned            quiet_cycles = 0;

    generational_handle_table u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    // offer one request, with a gap first when gaps are enabled and a burst has run out
    task automatic send_request(t_func op, bit [IDX_W-1:0] idx, bit [VER_W-1:0] hver,
                                bit [ENT_W-1:0] ent);
        int gap;
        if (sender_gaps && burst_left == 0) begin
            gap = $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
            end
            burst_left = $urandom_range(1, 16);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDATA_W'({ent, hver, idx});
        s_axis_tuser  <= op;
        forever begin
            @(posedge i_clk);
            if (s_axis_tvalid && s_axis_tready) break;
        end
        sb.apply_request(op, idx, hver, ent);
        if (burst_left > 0) burst_left--;
    endtask

    // random request, mostly aimed at live slots with their current version
    task automatic random_request(int unsigned add_pct, int unsigned rem_pct,
                                  int unsigned get_pct);
        int unsigned      roll;
        t_func            op;
        bit [IDX_W-1:0]   idx;
        bit [VER_W-1:0]   hver;
        roll = $urandom_range(99);
        if (roll < add_pct) op = FUNC_ADD;
        else if (roll < add_pct + rem_pct) op = FUNC_REMOVE;
        else if (roll < add_pct + rem_pct + get_pct) op = FUNC_GET;
        else op = FUNC_SET;
        if (sb.used_count > 0 && $urandom_range(9) < 8)
            idx = IDX_W'($urandom_range(sb.used_count - 1));
        else
            idx = IDX_W'($urandom);
        roll = $urandom_range(9);
        if (roll < 7) hver = sb.version_mem[idx];
        else if (roll < 8) hver = sb.version_mem[idx] - 1'b1;
        else hver = VER_W'($urandom);
        send_request(op, idx, hver, ENT_W'($urandom));
    endtask

    // stop offering until every answer is back
    task automatic idle_until_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // stimulus
    initial begin
        sb = new();
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= FUNC_ADD;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, field extremes, stale handles, duplicate remove
        send_request(FUNC_GET, 10'd0, 8'h00, 32'h0);
        send_request(FUNC_REMOVE, 10'h3FF, 8'hFF, 32'hFFFF_FFFF);
        send_request(FUNC_SET, 10'd0, 8'h00, 32'h0);
        send_request(FUNC_ADD, 10'h3FF, 8'hFF, 32'h0);
        send_request(FUNC_ADD, 10'd0, 8'h00, 32'hFFFF_FFFF);
        send_request(FUNC_GET, 10'd0, sb.version_mem[0], 32'h0);
        send_request(FUNC_GET, 10'd1, sb.version_mem[1], 32'h0);
        send_request(FUNC_GET, 10'd1, 8'hFF, 32'h0);
        send_request(FUNC_GET, 10'd2, 8'h00, 32'h0);
        send_request(FUNC_SET, 10'd1, 8'h00, 32'hA5A5_5A5A);
        send_request(FUNC_GET, 10'd1, sb.version_mem[1], 32'h0);
        send_request(FUNC_REMOVE, 10'd0, 8'h00, 32'h0);
        send_request(FUNC_GET, 10'd0, 8'h00, 32'h0);
        send_request(FUNC_REMOVE, 10'd0, 8'h00, 32'h0);
        send_request(FUNC_ADD, 10'd0, 8'h00, 32'h1111_1111);
        send_request(FUNC_ADD, 10'd0, 8'h00, 32'h2222_2222);
        send_request(FUNC_ADD, 10'd0, 8'h00, 32'h3333_3333);
        send_request(FUNC_GET, 10'd0, sb.version_mem[0], 32'h0);
        send_request(FUNC_GET, 10'h3FF, 8'hFF, 32'h0);
        send_request(FUNC_SET, 10'd2, 8'h00, 32'h1234_5678);
        send_request(FUNC_GET, 10'd2, sb.version_mem[2], 32'h0);
        idle_until_drained();

        // random mix, bursty sender, random receiver stalls
        sender_gaps = 1'b1;
        ready_mode  = READY_RANDOM;
        repeat (80) random_request(30, 15, 35);

        // long receiver hold-off while requests keep coming
        sender_gaps = 1'b0;
        hold_requests++;
        repeat (16) random_request(25, 15, 40);
        idle_until_drained();

        // fill every slot, then hit the full table
        ready_mode = READY_PATTERN;
        while (sb.free_count != 0 || sb.used_count != TABLE_SLOTS)
            random_request(100, 0, 0);
        repeat (3) send_request(FUNC_ADD, IDX_W'($urandom), VER_W'($urandom),
                                ENT_W'($urandom));
        idle_until_drained();

        // final mix with changing idle behavior
        repeat (2) begin
            sender_gaps = 1'($urandom_range(1));
            ready_mode  = t_ready_mode'($urandom_range(2));
            repeat (20) random_request(35, 20, 30);
        end
        idle_until_drained();

        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("generational_handle_table: match");
        end else begin
            $display("generational_handle_table: mismatch");
        end
        $finish;
    end

    // result receiver: own stall pattern plus a counted hold-off on request
    initial begin
        int unsigned hold_left;
        int unsigned holds_seen;
        bit [6:0]    stall_pattern;
        hold_left     = 0;
        holds_seen    = 0;
        stall_pattern = 7'b1100101;
        m_axis_tready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_seen != hold_requests) begin
                holds_seen = hold_requests;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                case (ready_mode)
                    READY_ALWAYS: m_axis_tready <= 1'b1;
                    READY_RANDOM: m_axis_tready <= ($urandom_range(3) != 0);
                    default: begin
                        m_axis_tready <= stall_pattern[0];
                        stall_pattern = {stall_pattern[0], stall_pattern[6:1]};
                    end
                endcase
            end
        end
    end

    // check each accepted result
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            observed.status  = t_status'(m_axis_tuser);
            observed.index   = m_axis_tdata[IDX_W-1:0];
            observed.version = m_axis_tdata[IDX_W +: VER_W];
            observed.entity  = m_axis_tdata[IDX_W+VER_W +: ENT_W];
            sb.compare_result(observed);
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("generational_handle_table: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
